// ===== src/skrt_pkg.sv =====
// ----------------------------------------------------------------------------
// skrt_pkg: shared definitions of the sorted keyed record table
// Function, status and result source codes, port widths, and the command
// and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package skrt_pkg;

    // Port field widths and default sizes
    localparam int PORT_FIELD_W    = 16;
    localparam int FUNC_W          = 3;
    localparam int STATUS_W        = 3;
    localparam int SRC_W           = 3;
    localparam int S_TDATA_W       = 56;
    localparam int M_TDATA_W       = 48;
    localparam int CAPACITY_DEF    = 32;
    localparam int FIELD_BITS_DEF  = 16;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_UPDATE    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LIST_ASC  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_LIST_DESC = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Where the fields of a single result come from
    localparam logic [SRC_W-1:0] SRC_NONE = 3'd0;  // all fields zero
    localparam logic [SRC_W-1:0] SRC_ECHO = 3'd1;  // request key, zero values
    localparam logic [SRC_W-1:0] SRC_MEM  = 3'd2;  // record read from the table
    localparam logic [SRC_W-1:0] SRC_NEW  = 3'd3;  // request fields
    localparam logic [SRC_W-1:0] SRC_UPD  = 3'd4;  // stored record merged with update

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SRC_W-1:0]    src_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;        // capture a request
        logic    scan_step;   // search for the lower bound of the key
        logic    upd_write;   // write the merged record back
        logic    up_start;    // open a shift toward higher indexes
        logic    up_step;
        logic    ins_write;   // write the new record at its slot
        logic    dn_start;    // open a shift toward lower indexes
        logic    dn_step;
        logic    list_step;   // stream out the table
        logic    emit;        // load a single result
        status_t emit_status;
        src_t    emit_src;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        func_t func;
        logic  eq;
        logic  full;
        logic  empty;
        logic  scan_done;
        logic  up_done;
        logic  dn_done;
        logic  list_done;
        logic  out_free;
    } sts_t;

endpackage

// ===== src/sorted_keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// sorted_keyed_record_table: bounded table of records kept in key order
// Insert, lookup, update, remove and ascending or descending listing over
// a table of key, speed and duration records.
// ----------------------------------------------------------------------------
// The block takes one request at a time; s_tready is high only while it is
// idle. Requests walk the record memory through its single read port and
// single write port, one entry per cycle, except that a listing holds while
// the output register is full. Lookup, update and a rejected insert take the
// search only. Insert and remove add a shift of the records above the slot,
// one per cycle. The search stops at that slot.
// A listing streams one record per cycle after the registered read, while
// the output is not stalled. A stalled result stays in the output register
// while the next request is accepted.
// Function codes 6 and 7 are accepted and produce no result.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table
    import skrt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int FIELD_BITS = FIELD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key, speed, duration, set_speed,
                                            // set_duration, zero pad
    input  logic [FUNC_W-1:0]    s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // rec_key, rec_speed, rec_duration
    output logic [STATUS_W-1:0]  m_tuser,   // status
    output logic                 m_tlast    // last
);

    cmd_t cmd;
    sts_t sts;

    skrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_func  (s_tuser),
        .sts      (sts),
        .ready    (s_tready),
        .cmd      (cmd)
    );

    skrt_dp #(
        .CAPACITY   (CAPACITY),
        .FIELD_BITS (FIELD_BITS)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .in_func  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A result that is not ok always closes its request
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
        else $error("non-ok result without last");

    // Never open a shift for insert into a full table
    a_no_shift_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.up_start |-> !sts.full)
        else $error("shift started on a full table");

    // The listing ends only while its final record can be loaded
    a_list_end_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.list_step && sts.list_done) |=> (m_tvalid && m_tlast))
        else $error("listing ended without its last record");

    // A single result is loaded only into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending transaction");

endmodule

// ===== src/skrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skrt_ctrl: sequencer of the sorted keyed record table
// Steps each request through search, shift, write, result and listing phases and
// drives the datapath by command; it holds the pending result code.
// ----------------------------------------------------------------------------
module skrt_ctrl
    import skrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    input  func_t in_func,
    input  sts_t  sts,
    output logic  ready,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_UPSHIFT = 3'd3;
    localparam logic [2:0] S_INSWR   = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;
    localparam logic [2:0] S_DNSHIFT = 3'd6;
    localparam logic [2:0] S_LIST    = 3'd7;

    logic [2:0] state_reg, state_next;
    status_t    st_reg, st_next;
    src_t       src_reg, src_next;

    // Sequence the phases of one request
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        src_next   = src_reg;
        cmd        = '0;
        cmd.emit_status = st_reg;
        cmd.emit_src    = src_reg;
        ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (in_func inside {FN_INSERT, FN_LOOKUP, FN_UPDATE, FN_REMOVE})
                    begin
                        state_next = S_SCAN;
                    end
                    else if (in_func inside {FN_LIST_ASC, FN_LIST_DESC})
                    begin
                        if (sts.empty)
                        begin
                            st_next    = ST_EMPTY;
                            src_next   = SRC_NONE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_LIST;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_EMIT;
                if (sts.func == FN_INSERT)
                begin
                    if (sts.eq)
                    begin
                        st_next  = ST_DUPLICATE;
                        src_next = SRC_MEM;
                    end
                    else if (sts.full)
                    begin
                        st_next  = ST_FULL;
                        src_next = SRC_ECHO;
                    end
                    else
                    begin
                        cmd.up_start = 1'b1;
                        state_next   = S_UPSHIFT;
                    end
                end
                else if (!sts.eq)
                begin
                    st_next  = ST_NOT_FOUND;
                    src_next = SRC_ECHO;
                end
                else if (sts.func == FN_UPDATE)
                begin
                    cmd.upd_write = 1'b1;
                    st_next       = ST_OK;
                    src_next      = SRC_UPD;
                end
                else
                begin
                    st_next  = ST_OK;
                    src_next = SRC_MEM;
                end
            end
            S_UPSHIFT:
            begin
                cmd.up_step = 1'b1;
                if (sts.up_done)
                begin
                    state_next = S_INSWR;
                end
            end
            S_INSWR:
            begin
                cmd.ins_write = 1'b1;
                st_next       = ST_OK;
                src_next      = SRC_NEW;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                // Hold until the output register is free
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.func == FN_REMOVE && st_reg == ST_OK)
                    begin
                        cmd.dn_start = 1'b1;
                        state_next   = S_DNSHIFT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DNSHIFT:
            begin
                cmd.dn_step = 1'b1;
                if (sts.dn_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                cmd.list_step = 1'b1;
                if (sts.list_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            src_reg   <= SRC_NONE;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            src_reg   <= src_next;
        end
    end

endmodule

// ===== src/skrt_dp.sv =====
// ----------------------------------------------------------------------------
// skrt_dp: datapath of the sorted keyed record table
// Holds the request, the record memory with its registered read port, the
// walk counter shared by search, shifts and listing, and the result register.
// ----------------------------------------------------------------------------
module skrt_dp
    import skrt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int FIELD_BITS = FIELD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  func_t                in_func,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output status_t              m_tuser,
    output logic                 m_tlast
);

    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FB    = FIELD_BITS;
    localparam int RW    = 3 * FIELD_BITS;
    localparam int PW    = PORT_FIELD_W;

    // Request
    func_t             func_reg;
    logic [FB-1:0]     key_reg, speed_reg, dur_reg;
    logic              set_s_reg, set_d_reg;

    // Table and walk state
    logic [RW-1:0]     mem [CAPACITY];
    logic [RW-1:0]     rdata_reg;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic              pend_reg, pend_next;
    logic              eq_reg, eq_next;
    logic [AW-1:0]     wa_reg, wa_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [PW-1:0]     out_key_reg, out_key_next;
    logic [PW-1:0]     out_speed_reg, out_speed_next;
    logic [PW-1:0]     out_dur_reg, out_dur_next;
    logic              out_last_reg, out_last_next;

    // Memory port
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [RW-1:0]     wr_data;

    logic [FB-1:0]     rkey, rspeed, rdur, new_speed, new_dur;
    logic              scan_hit, scan_done, up_done, dn_done;
    logic              out_free, list_adv, list_more, list_done;
    logic [IDX_W-1:0]  idx_dec, idx_inc, list_addr;

    assign rkey      = rdata_reg[RW-1 -: FB];
    assign rspeed    = rdata_reg[2*FB-1 -: FB];
    assign rdur      = rdata_reg[FB-1:0];
    assign new_speed = set_s_reg ? speed_reg : rspeed;
    assign new_dur   = set_d_reg ? dur_reg : rdur;

    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;

    // Search ends on the first stored key not below the request, or at the end
    assign scan_hit  = pend_reg && (rkey >= key_reg);
    assign scan_done = scan_hit || (idx_reg == count_reg);
    assign up_done   = (idx_reg == pos_reg) && !pend_reg;
    assign dn_done   = (idx_reg == count_reg) && !pend_reg;

    assign out_free  = !out_valid_reg || m_tready;
    assign list_adv  = !pend_reg || out_free;
    assign list_more = (idx_reg != count_reg);
    assign list_done = pend_reg && out_free && !list_more;
    assign list_addr = (func_reg == FN_LIST_ASC) ? idx_reg : (count_reg - 1'b1 - idx_reg);

    assign sts.func      = func_reg;
    assign sts.eq        = eq_reg;
    assign sts.full      = (count_reg == IDX_W'(CAPACITY));
    assign sts.empty     = (count_reg == '0);
    assign sts.scan_done = scan_done;
    assign sts.up_done   = up_done;
    assign sts.dn_done   = dn_done;
    assign sts.list_done = list_done;
    assign sts.out_free  = out_free;

    // Drive the memory port for the active phase
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = wa_reg;
        wr_data = rdata_reg;
        if (cmd.scan_step && !scan_done)
        begin
            rd_en = 1'b1;
        end
        if (cmd.up_step)
        begin
            wr_en   = pend_reg;
            rd_en   = (idx_reg != pos_reg);
            rd_addr = idx_dec[AW-1:0];
        end
        if (cmd.dn_step)
        begin
            wr_en = pend_reg;
            rd_en = (idx_reg != count_reg);
        end
        if (cmd.upd_write)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[AW-1:0];
            wr_data = {rkey, new_speed, new_dur};
        end
        if (cmd.ins_write)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[AW-1:0];
            wr_data = {key_reg, speed_reg, dur_reg};
        end
        if (cmd.list_step && list_adv && list_more)
        begin
            rd_en   = 1'b1;
            rd_addr = list_addr[AW-1:0];
        end
    end

    // Advance the walk counter, the bound and the fill count
    always_comb
    begin
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        eq_next    = eq_reg;
        wa_next    = wa_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (scan_done)
            begin
                pos_next = scan_hit ? idx_dec : idx_reg;
                eq_next  = scan_hit && (rkey == key_reg);
            end
            else
            begin
                idx_next  = idx_inc;
                pend_next = 1'b1;
            end
        end
        if (cmd.up_start)
        begin
            idx_next  = count_reg;
            pend_next = 1'b0;
        end
        if (cmd.up_step)
        begin
            pend_next = (idx_reg != pos_reg);
            if (idx_reg != pos_reg)
            begin
                wa_next  = idx_reg[AW-1:0];
                idx_next = idx_dec;
            end
        end
        if (cmd.ins_write)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.dn_start)
        begin
            idx_next  = pos_reg + 1'b1;
            pend_next = 1'b0;
        end
        if (cmd.dn_step)
        begin
            pend_next = (idx_reg != count_reg);
            if (idx_reg != count_reg)
            begin
                wa_next  = idx_dec[AW-1:0];
                idx_next = idx_inc;
            end
            if (dn_done)
            begin
                count_next = count_reg - 1'b1;
            end
        end
        if (cmd.list_step && list_adv)
        begin
            pend_next = list_more;
            if (list_more)
            begin
                idx_next = idx_inc;
            end
        end
    end

    // Load the result register from a single result or the listing stream
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_speed_next  = out_speed_reg;
        out_dur_next    = out_dur_reg;
        out_last_next   = out_last_reg;
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.emit_status;
            out_last_next   = 1'b1;
            case (cmd.emit_src)
                SRC_ECHO:
                begin
                    out_key_next   = PW'(key_reg);
                    out_speed_next = '0;
                    out_dur_next   = '0;
                end
                SRC_MEM:
                begin
                    out_key_next   = PW'(rkey);
                    out_speed_next = PW'(rspeed);
                    out_dur_next   = PW'(rdur);
                end
                SRC_NEW:
                begin
                    out_key_next   = PW'(key_reg);
                    out_speed_next = PW'(speed_reg);
                    out_dur_next   = PW'(dur_reg);
                end
                SRC_UPD:
                begin
                    out_key_next   = PW'(rkey);
                    out_speed_next = PW'(new_speed);
                    out_dur_next   = PW'(new_dur);
                end
                default:
                begin
                    out_key_next   = '0;
                    out_speed_next = '0;
                    out_dur_next   = '0;
                end
            endcase
        end
        if (cmd.list_step && list_adv && pend_reg)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_key_next    = PW'(rkey);
            out_speed_next  = PW'(rspeed);
            out_dur_next    = PW'(rdur);
            out_last_next   = !list_more;
        end
    end

    // Record memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Request, walk state and result payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_func;
            key_reg   <= FB'(s_tdata[15:0]);
            speed_reg <= FB'(s_tdata[31:16]);
            dur_reg   <= FB'(s_tdata[47:32]);
            set_s_reg <= s_tdata[48];
            set_d_reg <= s_tdata[49];
        end
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        eq_reg         <= eq_next;
        wa_reg         <= wa_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_speed_reg  <= out_speed_next;
        out_dur_reg    <= out_dur_next;
        out_last_reg   <= out_last_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_dur_reg, out_speed_reg, out_key_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sim/record_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_table_checker: result checker for the sorted keyed record table
// Watches both stream channels and keeps its own sorted copy of the table.
// For each accepted request it queues the records the block should return,
// then compares every accepted result field by field with the oldest one.
// ----------------------------------------------------------------------------
module record_table_checker
    import skrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key, speed, duration, set_speed,
                                            // set_duration, zero pad
    input  func_t                s_tuser,   // func
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // rec_key, rec_speed, rec_duration
    input  status_t              m_tuser,   // status
    input  logic                 m_tlast,   // last
    output int                   fail_count,
    output int                   pending_results,
    output int                   results_checked
);

    typedef logic [PORT_FIELD_W-1:0] field_t;

    typedef struct packed {
        status_t status;
        field_t  key;
        field_t  speed;
        field_t  dur;
        logic    last;
    } record_out_t;

    // Predicted table contents, sorted by key
    field_t tbl_key   [CAPACITY_DEF];
    field_t tbl_speed [CAPACITY_DEF];
    field_t tbl_dur   [CAPACITY_DEF];
    int     fill;

    record_out_t awaited_records[$];
    record_out_t want;
    int          mismatches;
    int          checked;

    function automatic void note_result(input status_t st, input field_t k,
                                        input field_t s, input field_t d,
                                        input logic fin);
        record_out_t r;
        r.status = st;
        r.key    = k;
        r.speed  = s;
        r.dur    = d;
        r.last   = fin;
        awaited_records.push_back(r);
    endfunction

    // Apply one request to the predicted table and queue its results
    task automatic table_op(input func_t fn, input field_t key, input field_t speed,
                            input field_t dur, input logic set_spd, input logic set_dur);
        int  pos;
        int  j;
        int  idx;
        bit  hit;
        pos = 0;
        while (pos < fill && tbl_key[pos] < key)
            pos++;
        hit = (pos < fill) && (tbl_key[pos] == key);
        case (fn)
            FN_INSERT:
            begin
                if (hit)
                    note_result(ST_DUPLICATE, key, tbl_speed[pos], tbl_dur[pos], 1'b1);
                else if (fill >= CAPACITY_DEF)
                    note_result(ST_FULL, key, '0, '0, 1'b1);
                else
                begin
                    for (j = fill; j > pos; j--)
                    begin
                        tbl_key[j]   = tbl_key[j-1];
                        tbl_speed[j] = tbl_speed[j-1];
                        tbl_dur[j]   = tbl_dur[j-1];
                    end
                    tbl_key[pos]   = key;
                    tbl_speed[pos] = speed;
                    tbl_dur[pos]   = dur;
                    fill++;
                    note_result(ST_OK, key, speed, dur, 1'b1);
                end
            end
            FN_LOOKUP, FN_UPDATE, FN_REMOVE:
            begin
                if (!hit)
                    note_result(ST_NOT_FOUND, key, '0, '0, 1'b1);
                else
                begin
                    if (fn == FN_UPDATE)
                    begin
                        if (set_spd)
                            tbl_speed[pos] = speed;
                        if (set_dur)
                            tbl_dur[pos] = dur;
                    end
                    note_result(ST_OK, tbl_key[pos], tbl_speed[pos], tbl_dur[pos], 1'b1);
                    // Close the gap left by a removed record
                    if (fn == FN_REMOVE)
                    begin
                        for (j = pos; j + 1 < fill; j++)
                        begin
                            tbl_key[j]   = tbl_key[j+1];
                            tbl_speed[j] = tbl_speed[j+1];
                            tbl_dur[j]   = tbl_dur[j+1];
                        end
                        fill--;
                    end
                end
            end
            FN_LIST_ASC, FN_LIST_DESC:
            begin
                if (fill == 0)
                    note_result(ST_EMPTY, '0, '0, '0, 1'b1);
                else
                begin
                    for (j = 0; j < fill; j++)
                    begin
                        idx = (fn == FN_LIST_ASC) ? j : fill - 1 - j;
                        note_result(ST_OK, tbl_key[idx], tbl_speed[idx], tbl_dur[idx],
                                    j == fill - 1);
                    end
                end
            end
            default:
            begin
                // undefined codes leave the table alone and return nothing
            end
        endcase
    endtask

    function automatic int field_bad(input string name, input field_t exp_val,
                                     input field_t act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    // Check results first: a result taken at this edge belongs to an earlier request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_records.delete();
            fill            = 0;
            mismatches      = 0;
            checked         = 0;
            fail_count      <= 0;
            pending_results <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_records.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d, key 0x%0h",
                           m_tuser, m_tdata[15:0]);
                    mismatches++;
                end
                else
                begin
                    want = awaited_records.pop_front();
                    mismatches += field_bad("status", field_t'(want.status),
                                            field_t'(m_tuser))
                                + field_bad("rec_key", want.key, m_tdata[15:0])
                                + field_bad("rec_speed", want.speed, m_tdata[31:16])
                                + field_bad("rec_duration", want.dur, m_tdata[47:32])
                                + field_bad("last", field_t'(want.last), field_t'(m_tlast));
                    checked++;
                end
            end
            if (s_tvalid && s_tready)
                table_op(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                         s_tdata[48], s_tdata[49]);
            fail_count      <= mismatches;
            pending_results <= awaited_records.size();
            results_checked <= checked;
        end
    end

endmodule

// ===== sim/sorted_keyed_record_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_keyed_record_table_test: stimulus and verdict for the record table
// Drives directed requests covering empty, duplicate, missing-key and update
// cases, then fills the table past capacity, mixes random operations and
// drains it again, with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table_test;
    import skrt_pkg::*;

    localparam int    IDLE_LIMIT   = 2000;
    localparam int    DRAIN_CYCLES = 100;
    localparam int    POOL_N       = 48;
    localparam func_t FN_UNDEF_LO  = 3'd6;
    localparam func_t FN_UNDEF_HI  = 3'd7;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // key, speed, duration, set_speed,
                                          // set_duration, zero pad
    func_t                s_tuser  = FN_LOOKUP;  // func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // rec_key, rec_speed, rec_duration
    status_t              m_tuser;  // status
    logic                 m_tlast;  // last

    int fail_count;
    int pending_results;
    int results_checked;

    int          burst_left = 0;
    int          fn_count [8];
    logic [15:0] key_pool [POOL_N];

    int          stall_phase = 0;
    int          stall_mode  = 0;
    logic [15:0] stall_word  = 16'hFFFF;
    int          idle_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sorted_keyed_record_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    record_table_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // Stall the result channel: always ready, a repeating bit pattern, or sparse
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 2);
            stall_word  = 16'($urandom) | 16'h0001;
            stall_phase = $urandom_range(20, 80);
        end
        stall_phase--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= stall_word[4'(stall_phase % 16)];
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // End the run when no transaction happens on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Present one request in bursts with random gaps; hold until accepted
    task automatic send_request(input func_t fn, input logic [15:0] key,
                                input logic [15:0] speed, input logic [15:0] dur,
                                input logic set_spd, input logic set_dur);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {6'b0, set_dur, set_spd, dur, speed, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        fn_count[fn]++;
    endtask

    task automatic send_random(input func_t fn, input logic [15:0] key);
        send_request(fn, key, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int    pick;
        func_t fn;

        foreach (fn_count[i])
            fn_count[i] = 0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        key_pool[2] = 16'h8000;
        for (int i = 3; i < POOL_N; i++)
            key_pool[i] = 16'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, missing keys, extremes, updates, undefined codes
        send_request(FN_LIST_ASC, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_LIST_DESC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_request(FN_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_UPDATE, 16'hFFFF, 16'h1111, 16'h2222, 1'b1, 1'b1);
        send_request(FN_REMOVE, 16'h1234, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_INSERT, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_request(FN_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
        send_request(FN_INSERT, 16'h8000, 16'h1234, 16'h5678, 1'b0, 1'b1);
        send_request(FN_INSERT, 16'h0000, 16'hAAAA, 16'h5555, 1'b1, 1'b0);
        send_request(FN_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1);
        send_request(FN_UPDATE, 16'h8000, 16'hA5A5, 16'hDEAD, 1'b1, 1'b0);
        send_request(FN_UPDATE, 16'h8000, 16'hBEEF, 16'h5A5A, 1'b0, 1'b1);
        send_request(FN_UPDATE, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
        send_request(FN_UPDATE, 16'h0000, 16'h4321, 16'h8765, 1'b0, 1'b0);
        send_request(FN_LIST_ASC, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_LIST_DESC, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_UNDEF_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_request(FN_UNDEF_HI, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_REMOVE, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_REMOVE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(FN_LIST_ASC, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);

        // Fill past capacity so the last inserts are rejected as full
        for (int n = 0; n < 40; n++)
            send_random(FN_INSERT, key_pool[n]);
        send_random(FN_LIST_ASC, 16'($urandom));
        send_random(FN_LIST_DESC, 16'($urandom));

        // Mixed operations on pool keys, with noise
        for (int n = 0; n < 35; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                fn = FN_INSERT;
            else if (pick < 40)
                fn = FN_LOOKUP;
            else if (pick < 60)
                fn = FN_UPDATE;
            else if (pick < 75)
                fn = FN_REMOVE;
            else if (pick < 85)
                fn = ($urandom_range(0, 1) != 0) ? FN_LIST_ASC : FN_LIST_DESC;
            else
                fn = ($urandom_range(0, 1) != 0) ?
                     func_t'($urandom_range(FN_UNDEF_LO, FN_UNDEF_HI)) : FN_LOOKUP;
            if (pick >= 85)
                send_random(fn, 16'($urandom));
            else
                send_random(fn, key_pool[6'($urandom_range(0, POOL_N - 1))]);
        end

        // Drain every pool key, then list the empty table
        for (int n = 0; n < POOL_N; n++)
        begin
            send_random(FN_REMOVE, key_pool[n]);
            if ($urandom_range(0, 7) == 0)
                send_random(FN_LIST_DESC, 16'($urandom));
        end
        send_random(FN_LIST_ASC, 16'($urandom));

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d inserts, %0d lookups, %0d updates, %0d removes, %0d listings, %0d undefined codes",
                 fn_count[FN_INSERT], fn_count[FN_LOOKUP], fn_count[FN_UPDATE],
                 fn_count[FN_REMOVE], fn_count[FN_LIST_ASC] + fn_count[FN_LIST_DESC],
                 fn_count[FN_UNDEF_LO] + fn_count[FN_UNDEF_HI]);
        $display("Compared %0d result transactions, table filled to capacity and drained",
                 results_checked);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/skrt_pkg.sv
src/skrt_ctrl.sv
src/skrt_dp.sv
src/sorted_keyed_record_table.sv
sim/record_table_checker.sv
sim/sorted_keyed_record_table_test.sv
